/* rtl/core/cpra_pkg.sv */
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared types and constants of the contiguous page run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

  localparam int DEF_SLOT_COUNT = 64;
  localparam int DEF_PAGE_BITS  = 12;

  localparam int SIZE_W   = 32;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK             = 3'd0;
  localparam status_t ST_NO_SPACE       = 3'd1;
  localparam status_t ST_SIZE_UNALIGNED = 3'd2;
  localparam status_t ST_OUT_OF_RANGE   = 3'd3;
  localparam status_t ST_ADDR_UNALIGNED = 3'd4;
  localparam status_t ST_NOT_MAPPED     = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // finished result, held by the controller until the output stage takes it
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } res_t;

endpackage

/* rtl/core/cpra_ram.sv */
// ----------------------------------------------------------------------------
// cpra_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cpra_ctrl.sv */
// ----------------------------------------------------------------------------
// cpra_ctrl
// Sequencer for the run map: clearing pass, first-fit scan, run marking and
// run freeing, all through one read and one write port of the map RAM.
// ----------------------------------------------------------------------------
module cpra_ctrl #(
  parameter int SLOT_COUNT = cpra_pkg::DEF_SLOT_COUNT,
  parameter int PAGE_BITS  = cpra_pkg::DEF_PAGE_BITS,
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic                        op,
  input  logic [cpra_pkg::SIZE_W-1:0] size_bytes,
  input  logic [cpra_pkg::ADDR_W-1:0] free_address,
  input  logic [cpra_pkg::ADDR_W-1:0] region_base,
  output logic                        idle,
  output cpra_pkg::res_t              res,
  input  logic                        res_ack,
  output logic                        ram_we,
  output logic [SW-1:0]               ram_waddr,
  output logic [CW-1:0]               ram_wdata,
  output logic [SW-1:0]               ram_raddr,
  input  logic [CW-1:0]               ram_rdata
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_FCHK = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FGO  = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [cpra_pkg::SIZE_W-1:0] SIZE_MASK =
    cpra_pkg::SIZE_W'((64'(1) << PAGE_BITS) - 64'(1));
  localparam logic [cpra_pkg::ADDR_W-1:0] ADDR_MASK =
    (64'(1) << PAGE_BITS) - 64'(1);

  logic [3:0]                  state;
  logic [SW-1:0]               wptr;      // clear / mark / init pointer
  logic [CW-1:0]               left;      // slots still to write
  logic [CW-1:0]               need;      // free slots the run needs (>= 1)
  logic                        zero_len;  // zero-size alloc: no marking
  logic [SW-1:0]               scan_idx;
  logic                        scan_end;  // last read issued
  logic                        pend;      // read data for chk_idx arrives now
  logic [SW-1:0]               chk_idx;
  logic [CW-1:0]               cur_len;
  logic [SW-1:0]               cur_start;
  logic [SW-1:0]               slot;
  logic [cpra_pkg::ADDR_W-1:0] va;
  logic [cpra_pkg::ADDR_W-1:0] res_addr;
  cpra_pkg::status_t           res_status;

  logic [cpra_pkg::SIZE_W-1:0] pages;
  logic [cpra_pkg::ADDR_W:0]   diff;
  logic [cpra_pkg::ADDR_W-1:0] slot_wide;
  logic [CW-1:0]               len_next;
  logic [SW-1:0]               start_next;
  logic [CW-1:0]               lim;

  assign pages      = size_bytes >> PAGE_BITS;
  assign diff       = {1'b0, va} - {1'b0, region_base};
  assign slot_wide  = diff[cpra_pkg::ADDR_W-1:0] >> PAGE_BITS;
  assign len_next   = cur_len + CW'(1);
  assign start_next = (cur_len == '0) ? chk_idx : cur_start;
  assign lim        = CW'(SLOT_COUNT) - CW'(slot);

  assign idle = (state == {1'b0, S_IDLE});

  assign res.valid  = (state == S_RESP);
  assign res.addr   = res_addr;
  assign res.status = res_status;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr;
    ram_wdata = '0;
    ram_raddr = scan_idx;
    case (state)
      {1'b0, S_INIT}, {1'b0, S_CLR}: begin
        ram_we = 1'b1;
      end
      {1'b0, S_MARK}: begin
        ram_we    = 1'b1;
        ram_wdata = left;
      end
      {1'b0, S_FRD}: begin
        ram_raddr = slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= {1'b0, S_INIT};
      wptr  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        {1'b0, S_INIT}: begin
          wptr <= wptr + SW'(1);
          if (wptr == LAST_SLOT) begin
            state <= {1'b0, S_IDLE};
          end
        end

        {1'b0, S_IDLE}: begin
          if (in_fire) begin
            res_addr <= '0;
            va       <= free_address;
            if (op == cpra_pkg::OP_FREE) begin
              state <= {1'b0, S_FCHK};
            end else if ((size_bytes & SIZE_MASK) != '0) begin
              res_status <= cpra_pkg::ST_SIZE_UNALIGNED;
              state      <= S_RESP;
            end else if (pages > cpra_pkg::SIZE_W'(SLOT_COUNT)) begin
              res_status <= cpra_pkg::ST_NO_SPACE;
              state      <= S_RESP;
            end else begin
              need     <= (pages == '0) ? CW'(1) : CW'(pages);
              zero_len <= (pages == '0);
              scan_idx <= '0;
              scan_end <= 1'b0;
              pend     <= 1'b0;
              cur_len  <= '0;
              state    <= {1'b0, S_SCAN};
            end
          end
        end

        // reads stream one slot a cycle; data for chk_idx lands in the cycle after its read
        {1'b0, S_SCAN}: begin
          if (!scan_end) begin
            scan_idx <= scan_idx + SW'(1);
            scan_end <= (scan_idx == LAST_SLOT);
          end
          pend    <= !scan_end;
          chk_idx <= scan_idx;
          if (pend) begin
            if (ram_rdata == '0) begin
              cur_len   <= len_next;
              cur_start <= start_next;
            end else begin
              cur_len <= '0;
            end
            if (ram_rdata == '0 && len_next == need) begin
              res_addr   <= region_base +
                            (cpra_pkg::ADDR_W'(start_next) << PAGE_BITS);
              res_status <= cpra_pkg::ST_OK;
              wptr       <= start_next;
              left       <= need;
              state      <= zero_len ? S_RESP : {1'b0, S_MARK};
            end else if (chk_idx == LAST_SLOT) begin
              res_status <= cpra_pkg::ST_NO_SPACE;
              state      <= S_RESP;
            end
          end
        end

        {1'b0, S_MARK}, {1'b0, S_CLR}: begin
          wptr <= wptr + SW'(1);
          left <= left - CW'(1);
          if (left == CW'(1)) begin
            state <= S_RESP;
          end
        end

        {1'b0, S_FCHK}: begin
          if (diff[cpra_pkg::ADDR_W] ||
              slot_wide >= cpra_pkg::ADDR_W'(SLOT_COUNT)) begin
            res_status <= cpra_pkg::ST_OUT_OF_RANGE;
            state      <= S_RESP;
          end else if ((va & ADDR_MASK) != '0) begin
            res_status <= cpra_pkg::ST_ADDR_UNALIGNED;
            state      <= S_RESP;
          end else begin
            slot  <= SW'(slot_wide);
            state <= {1'b0, S_FRD};
          end
        end

        {1'b0, S_FRD}: begin
          state <= {1'b0, S_FGO};
        end

        {1'b0, S_FGO}: begin
          if (ram_rdata == '0) begin
            res_status <= cpra_pkg::ST_NOT_MAPPED;
            state      <= S_RESP;
          end else begin
            // clamp the count at the map end so the clear stays inside the map
            left       <= (ram_rdata > lim) ? lim : ram_rdata;
            wptr       <= slot;
            res_status <= cpra_pkg::ST_OK;
            state      <= {1'b0, S_CLR};
          end
        end

        S_RESP: begin
          if (res_ack) begin
            state <= {1'b0, S_IDLE};
          end
        end

        default: begin
          state <= {1'b0, S_IDLE};
        end
      endcase
    end
  end

endmodule

/* rtl/core/contiguous_page_run_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// First-fit allocator of contiguous page runs over a map of page slots.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: operation; tdata: size, address
//  m_axis    out  m_axis_tvalid/tready       tdata: result_address, status
//  cfg       in   cfg_we                     cfg_wdata: region_base
//
//  Alloc: accept, map scan (one RAM read per cycle), marking of the run's pages
//  (none for a zero size), hand-over. Free: range and alignment check, read of
//  the run count, clearing of the run through the one RAM write port, hand-over.
//  After reset a clearing pass over every slot runs before the first item.
//  A finished item sits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator #(
  parameter int SLOT_COUNT = cpra_pkg::DEF_SLOT_COUNT,
  parameter int PAGE_BITS  = cpra_pkg::DEF_PAGE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [31:0] size_bytes, [95:32] free_address
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] result_address, [66:64] status
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [cpra_pkg::ADDR_W-1:0] region_base;
  logic                        in_fire;
  logic                        res_ack;
  cpra_pkg::res_t              res;
  logic                        ram_we;
  logic [SW-1:0]               ram_waddr;
  logic [CW-1:0]               ram_wdata;
  logic [SW-1:0]               ram_raddr;
  logic [CW-1:0]               ram_rdata;
  logic [cpra_pkg::ADDR_W-1:0] out_addr;
  cpra_pkg::status_t           out_status;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign res_ack = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
    end else if (cfg_we) begin
      region_base <= cfg_wdata;
    end
  end

  cpra_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .op           (s_axis_tuser[0]),
    .size_bytes   (s_axis_tdata[31:0]),
    .free_address (s_axis_tdata[95:32]),
    .region_base  (region_base),
    .idle         (s_axis_tready),
    .res          (res),
    .res_ack      (res_ack),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  cpra_ram #(
    .WIDTH (CW),
    .DEPTH (SLOT_COUNT)
  ) u_run_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ack) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack && res.valid) begin
      out_addr   <= res.addr;
      out_status <= res.status;
    end
  end

  assign m_axis_tdata = {5'b0, out_status, out_addr};

`ifndef ASSERT_OFF
  a_one_item_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input taken while an item is still in work");

  a_result_taken_once: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res_ack) |=> !res.valid)
    else $error("result handed to output stage twice");

  a_fail_has_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != cpra_pkg::ST_OK) |-> (out_addr == '0))
    else $error("failed item carries a nonzero address");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status <= cpra_pkg::ST_NOT_MAPPED))
    else $error("status code out of range");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for contiguous_page_run_allocator: directed allocate and
// free corner cases, then random traffic over several region bases, checked
// item by item against a first-fit predictor that tracks the slot map.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CLK_PERIOD    = 20;
  localparam int          SLOTS         = cpra_pkg::DEF_SLOT_COUNT;
  localparam int          PG_BITS       = cpra_pkg::DEF_PAGE_BITS;
  localparam logic [63:0] PAGE_MASK     = (64'd1 << PG_BITS) - 64'd1;
  localparam int          SETTLE_CYCLES = 2 * SLOTS + 16;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          ITEMS_PER_BASE = 65;

  typedef struct {
    logic [63:0]       addr;
    cpra_pkg::status_t status;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // [31:0] size_bytes, [95:32] free_address
  logic [0:0]  s_axis_tuser = '0;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [63:0] result_address, [66:64] status
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  // predictor state
  logic [6:0]  run_count [SLOTS];
  logic [63:0] region_base;
  page_result_t pending_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  contiguous_page_run_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("contiguous_page_run_allocator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic page_result_t first_fit_alloc(input logic [31:0] size);
    page_result_t r;
    logic [63:0]  pages;
    bit           fits;
    r.addr   = '0;
    r.status = cpra_pkg::ST_NO_SPACE;
    if ((64'(size) & PAGE_MASK) != 0) begin
      r.status = cpra_pkg::ST_SIZE_UNALIGNED;
      return r;
    end
    pages = 64'(size) >> PG_BITS;
    for (int i = 0; i < SLOTS; i++) begin
      if (run_count[i] != 0) continue;
      if (pages > 64'(SLOTS - i)) break;
      fits = 1'b1;
      for (int j = i; j < i + int'(pages); j++) begin
        if (run_count[j] != 0) begin
          fits = 1'b0;
          break;
        end
      end
      if (fits) begin
        // counts run down to 1 at the last page of the run
        for (int j = i; j < i + int'(pages); j++) run_count[j] = 7'(i + int'(pages) - j);
        r.addr   = region_base + (64'(i) << PG_BITS);
        r.status = cpra_pkg::ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic cpra_pkg::status_t release_run(input logic [63:0] va);
    logic [63:0] slot;
    int          s;
    int          count;
    // range check goes ahead of the alignment check
    if (va < region_base) return cpra_pkg::ST_OUT_OF_RANGE;
    slot = (va - region_base) >> PG_BITS;
    if (slot >= 64'(SLOTS)) return cpra_pkg::ST_OUT_OF_RANGE;
    if ((va & PAGE_MASK) != 0) return cpra_pkg::ST_ADDR_UNALIGNED;
    s     = int'(slot);
    count = int'(run_count[s]);
    if (count == 0) return cpra_pkg::ST_NOT_MAPPED;
    if (count > SLOTS - s) count = SLOTS - s;
    for (int k = 0; k < count; k++) run_count[s + k] = '0;
    return cpra_pkg::ST_OK;
  endfunction

  // page-aligned address that lands in slot s, also for an unaligned base
  function automatic logic [63:0] slot_address(input int s);
    logic [63:0] va;
    va = region_base + (64'(s) << PG_BITS);
    if ((region_base & PAGE_MASK) != 0) va = (va & ~PAGE_MASK) + (64'd1 << PG_BITS);
    return va;
  endfunction

  // a used slot (if the map holds one), usually backed up to the head of its run
  function automatic int pick_run_head();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < SLOTS && run_count[s] == 0; n++) s = (s + 1) % SLOTS;
    if ($urandom_range(0, 3) != 0)
      while (s > 0 && run_count[s] != 0 && run_count[s - 1] == run_count[s] + 1) s--;
    return s;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic op, input logic [31:0] size, input logic [63:0] va);
    page_result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {va, size};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == cpra_pkg::OP_ALLOC) begin
      want = first_fit_alloc(size);
    end else begin
      want.addr   = '0;
      want.status = release_run(va);
    end
    pending_results.push_back(want);
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_region_base(input logic [63:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    region_base = value;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    page_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, m_axis_tdata[63:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.addr)
          note_mismatch("result_address", want.addr, m_axis_tdata[63:0]);
        if (m_axis_tdata[66:64] !== want.status)
          note_mismatch("status", 64'(want.status), 64'(m_axis_tdata[66:64]));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    logic [63:0] b;
    set_region_base(64'h0000_7FFF_0000_0000);
    b = region_base;
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_0000, '0);          // zero size, map empty
    send_item(cpra_pkg::OP_ALLOC, 32'hFFFF_FFFF, '1);          // unaligned size
    send_item(cpra_pkg::OP_ALLOC, 32'hFFFF_F000, '0);          // far larger than the map
    send_item(cpra_pkg::OP_ALLOC, 32'(SLOTS) << PG_BITS, '0);  // whole map in one run
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_0000, '0);          // zero size, nothing free
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_1000, '0);
    send_item(cpra_pkg::OP_FREE, 32'hFFFF_FFFF, b + (64'd5 << PG_BITS));  // tail of a run
    send_item(cpra_pkg::OP_FREE, '0, b + (64'd5 << PG_BITS));  // already free
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_0000, '0);          // lowest free slot
    send_item(cpra_pkg::OP_FREE, '0, b - 64'd1);
    send_item(cpra_pkg::OP_FREE, '0, b + (64'(SLOTS) << PG_BITS));
    send_item(cpra_pkg::OP_FREE, '0, b + 64'h800);             // mapped slot, bad alignment
    send_item(cpra_pkg::OP_FREE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(cpra_pkg::OP_FREE, '0, 64'h0);
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_3000, '0);
    send_item(cpra_pkg::OP_FREE, '0, b);                       // clears the whole map
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_1000, '0);
    send_item(cpra_pkg::OP_ALLOC, 32'(SLOTS - 1) << PG_BITS, '0);
    send_item(cpra_pkg::OP_FREE, '0, b + (64'(SLOTS - 1) << PG_BITS));
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_2000, '0);          // window would cross the end
    send_item(cpra_pkg::OP_ALLOC, 32'h0000_1000, '0);          // exactly the last slot
    send_item(cpra_pkg::OP_FREE, '0, b);
    send_item(cpra_pkg::OP_FREE, '0, b + (64'd1 << PG_BITS));
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] size;
    logic [63:0] va;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) size = $urandom_range(0, SLOTS + 6) << PG_BITS;
      else size = $urandom_range(0, 8) << PG_BITS;
      send_item(cpra_pkg::OP_ALLOC, size, {$urandom, $urandom});
    end else if (pick < 80) begin
      send_item(cpra_pkg::OP_FREE, $urandom, slot_address(pick_run_head()));
    end else if (pick < 87) begin
      size = ($urandom_range(0, 8) << PG_BITS) + $urandom_range(1, 32'(PAGE_MASK));
      send_item(cpra_pkg::OP_ALLOC, size, {$urandom, $urandom});
    end else if (pick < 94) begin
      va = slot_address($urandom_range(0, SLOTS + 2));
      case ($urandom_range(0, 2))
        0: va = va + 64'($urandom_range(1, 32'(PAGE_MASK)));
        1: va = region_base - 64'($urandom_range(1, 4096));
        default: ;
      endcase
      send_item(cpra_pkg::OP_FREE, $urandom, va);
    end else begin
      send_item(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom});
    end
  endtask

  task automatic test_random_traffic();
    logic [63:0] bases [5];
    bases[0] = 64'h0;
    bases[1] = 64'hFFFF_FFFF_FFFF_F000;
    bases[2] = 64'h0000_0000_0000_0ABC;
    bases[3] = 64'hFFFF_FFFF_FFFF_FFFF;
    bases[4] = {$urandom, $urandom} & ~PAGE_MASK;
    foreach (bases[p]) begin
      set_region_base(bases[p]);
      repeat (ITEMS_PER_BASE) random_item();
    end
  endtask

  // last stretch runs with both sides always ready
  task automatic test_back_to_back();
    settle_idle();
    idle_on = 1'b0;
    set_region_base({$urandom, $urandom});
    repeat (20) random_item();
    set_region_base(64'h0000_0000_0040_0000);
    repeat (30) random_item();
  endtask

  initial begin
    region_base = '0;
    foreach (run_count[i]) run_count[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic();
    test_back_to_back();
    settle_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("contiguous_page_run_allocator verification clean");
    end else begin
      $display("contiguous_page_run_allocator verification failed");
    end
    $finish;
  end

endmodule
